@@ rtl/asd_pkg.sv @@
package asd_pkg;

  localparam int AXIS_WIDTH_DEF  = 16;
  localparam int COUNT_WIDTH_DEF = 24;

  localparam int GAIN_W     = 9;
  localparam int THRESH_W   = 16;
  localparam int FILTER_W   = 24;
  localparam int LEVEL_W    = 16;
  localparam int STEPS_W    = 24;
  localparam int FRAC_SHIFT = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR  = 2'd2;

  localparam logic [GAIN_W-1:0]   GAIN_RESET     = 9'd26;
  localparam logic [THRESH_W-1:0] HIGH_THR_RESET = 16'd3456;
  localparam logic [THRESH_W-1:0] LOW_THR_RESET  = 16'd3187;

  localparam logic [FILTER_W-1:0] FILTER_MAX = {FILTER_W{1'b1}};

endpackage

@@ rtl/accel_step_detector.sv @@
// each sample is accepted in idle, squared and summed one axis at a time on the shared
//   squaring multiplier, reduced by the bit-serial square root, scaled by the gain and
//   committed in the update state, which waits until the output register is free; a new
//   sample is taken only in idle, so one sample is finished before the next is accepted
// a finished word waits in the output register while the next sample is taken
// reset (synchronous, active low) clears filter level, armed flag and step count
//   and loads the default gain and thresholds
module accel_step_detector #(
  parameter int AXIS_WIDTH  = asd_pkg::AXIS_WIDTH_DEF,
  parameter int COUNT_WIDTH = asd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [asd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [asd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [AXIS_WIDTH-1:0]       in_accel_x,
  input  logic signed [AXIS_WIDTH-1:0]       in_accel_y,
  input  logic signed [AXIS_WIDTH-1:0]       in_accel_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [asd_pkg::STEPS_W-1:0]        out_total_steps,
  output logic                               out_new_step,
  output logic                               out_armed_flag,
  output logic [asd_pkg::LEVEL_W-1:0]        out_smoothed_level
);
  import asd_pkg::*;

  localparam int SUM_W  = 2 * AXIS_WIDTH;
  localparam int MAG_W  = AXIS_WIDTH;
  localparam int REM_W  = AXIS_WIDTH + 3;
  localparam int CNT_W  = $clog2(AXIS_WIDTH + 1);
  localparam int DIFF_W = ((MAG_W + FRAC_SHIFT > FILTER_W) ? MAG_W + FRAC_SHIFT : FILTER_W) + 1;
  localparam int PROD_W = DIFF_W + GAIN_W + 1;

  localparam logic [CNT_W-1:0] AX_X     = CNT_W'(0);
  localparam logic [CNT_W-1:0] AX_Y     = CNT_W'(1);
  localparam logic [CNT_W-1:0] AX_Z     = CNT_W'(2);
  localparam logic [CNT_W-1:0] ROOT_TOP = CNT_W'(AXIS_WIDTH - 1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_SCALE,
    ST_UPDATE
  } state_t;

  state_t state_r, state_nxt;

  logic [GAIN_W-1:0]   gain_r, gain_nxt;
  logic [THRESH_W-1:0] high_r, high_nxt;
  logic [THRESH_W-1:0] low_r, low_nxt;

  logic [FILTER_W-1:0]    filt_r, filt_nxt;
  logic                   armed_r, armed_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;

  logic signed [AXIS_WIDTH-1:0] ax_r, ax_nxt;
  logic signed [AXIS_WIDTH-1:0] ay_r, ay_nxt;
  logic signed [AXIS_WIDTH-1:0] az_r, az_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [SUM_W-1:0]             sum_r, sum_nxt;
  logic [REM_W-1:0]             rem_r, rem_nxt;
  logic [MAG_W-1:0]             root_r, root_nxt;
  logic signed [PROD_W-1:0]     prod_r, prod_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [STEPS_W-1:0]    out_steps_r, out_steps_nxt;
  logic                  out_new_r, out_new_nxt;
  logic                  out_armed_r, out_armed_nxt;
  logic [LEVEL_W-1:0]    out_level_r, out_level_nxt;

  // shared squaring unit
  logic signed [AXIS_WIDTH-1:0] sq_op;
  logic signed [SUM_W-1:0]      sq_res;

  // square root step
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;

  // filter and detector
  logic signed [DIFF_W-1:0]  diff;
  logic signed [PROD_W-1:0]  inc;
  logic signed [PROD_W-1:0]  nf;
  logic [FILTER_W-1:0]       nf_sat;
  logic [LEVEL_W-1:0]        level;
  logic                      fire;
  logic                      armed_after;
  logic [COUNT_WIDTH-1:0]    count_after;
  logic [STEPS_W+COUNT_WIDTH-1:0] count_wide;

  always_comb begin
    case (cnt_r)
      AX_X:    sq_op = ax_r;
      AX_Y:    sq_op = ay_r;
      default: sq_op = az_r;
    endcase
    sq_res = SUM_W'(sq_op) * SUM_W'(sq_op);

    rem_sh = {rem_r[REM_W-3:0], sum_r[SUM_W-1:SUM_W-2]};
    trial  = {1'b0, root_r, 2'b01};

    diff = $signed({{(DIFF_W-MAG_W-FRAC_SHIFT){1'b0}}, root_r, {FRAC_SHIFT{1'b0}}})
         - $signed({{(DIFF_W-FILTER_W){1'b0}}, filt_r});

    inc = prod_r >>> FRAC_SHIFT;
    nf  = $signed({{(PROD_W-FILTER_W){1'b0}}, filt_r}) + inc;
    if (nf < 0) begin
      nf_sat = '0;
    end else if (nf > $signed({{(PROD_W-FILTER_W){1'b0}}, FILTER_MAX})) begin
      nf_sat = FILTER_MAX;
    end else begin
      nf_sat = nf[FILTER_W-1:0];
    end

    level       = nf_sat[FILTER_W-1:FRAC_SHIFT];
    fire        = !armed_r && (level > high_r);
    armed_after = (armed_r || fire) && !(level < low_r);
    if (fire && (count_r != COUNT_MAX)) begin
      count_after = count_r + 1'b1;
    end else begin
      count_after = count_r;
    end
    count_wide = {{STEPS_W{1'b0}}, count_after};
  end

  always_comb begin
    state_nxt     = state_r;
    gain_nxt      = gain_r;
    high_nxt      = high_r;
    low_nxt       = low_r;
    filt_nxt      = filt_r;
    armed_nxt     = armed_r;
    count_nxt     = count_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    az_nxt        = az_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r;
    out_steps_nxt = out_steps_r;
    out_new_nxt   = out_new_r;
    out_armed_nxt = out_armed_r;
    out_level_nxt = out_level_r;

    if (cfg_we) begin
      case (cfg_index)
        REG_GAIN:     gain_nxt = cfg_data[GAIN_W-1:0];
        REG_HIGH_THR: high_nxt = cfg_data[THRESH_W-1:0];
        REG_LOW_THR:  low_nxt  = cfg_data[THRESH_W-1:0];
        default:      ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ax_nxt    = in_accel_x;
          ay_nxt    = in_accel_y;
          az_nxt    = in_accel_z;
          cnt_nxt   = AX_X;
          sum_nxt   = '0;
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        sum_nxt = sum_r + $unsigned(sq_res);
        if (cnt_r == AX_Z) begin
          cnt_nxt   = ROOT_TOP;
          rem_nxt   = '0;
          root_nxt  = '0;
          state_nxt = ST_ROOT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_ROOT: begin
        sum_nxt = {sum_r[SUM_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_nxt  = rem_sh - trial;
          root_nxt = {root_r[MAG_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {root_r[MAG_W-2:0], 1'b0};
        end
        if (cnt_r == '0) begin
          state_nxt = ST_SCALE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_SCALE: begin
        prod_nxt  = PROD_W'($signed({1'b0, gain_r})) * PROD_W'(diff);
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        // commit only when the output register is free
        if (!out_valid_r || out_ready) begin
          filt_nxt      = nf_sat;
          armed_nxt     = armed_after;
          count_nxt     = count_after;
          out_valid_nxt = 1'b1;
          out_steps_nxt = count_wide[STEPS_W-1:0];
          out_new_nxt   = fire;
          out_armed_nxt = armed_after;
          out_level_nxt = level;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gain_r      <= GAIN_RESET;
      high_r      <= HIGH_THR_RESET;
      low_r       <= LOW_THR_RESET;
      filt_r      <= '0;
      armed_r     <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gain_r      <= gain_nxt;
      high_r      <= high_nxt;
      low_r       <= low_nxt;
      filt_r      <= filt_nxt;
      armed_r     <= armed_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ax_r        <= ax_nxt;
    ay_r        <= ay_nxt;
    az_r        <= az_nxt;
    cnt_r       <= cnt_nxt;
    sum_r       <= sum_nxt;
    rem_r       <= rem_nxt;
    root_r      <= root_nxt;
    prod_r      <= prod_nxt;
    out_steps_r <= out_steps_nxt;
    out_new_r   <= out_new_nxt;
    out_armed_r <= out_armed_nxt;
    out_level_r <= out_level_nxt;
  end

  assign in_ready           = (state_r == ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_total_steps    = out_steps_r;
  assign out_new_step       = out_new_r;
  assign out_armed_flag     = out_armed_r;
  assign out_smoothed_level = out_level_r;

endmodule
